// ----- src/ppra_pkg.sv -----
// ----------------------------------------------------------------------------
// ppra_pkg - shared definitions for the page frame refcount allocator
// Sizes, request and status codes, the queued command type and helpers.
// ----------------------------------------------------------------------------
package ppra_pkg;

   // frame table geometry
   localparam int NUM_FRAMES = 512;
   localparam int PAGE_BITS  = 12;

   // fixed field widths
   localparam int KIND_W   = 3;
   localparam int ADDR_W   = 22;
   localparam int INDEX_W  = 9;
   localparam int OWNER_W  = 5;
   localparam int STATUS_W = 3;
   localparam int FRNUM_W  = 9;
   localparam int REF_W    = 7;

   localparam logic [REF_W-1:0]   REF_MAX        = 7'd127;
   localparam logic [OWNER_W-1:0] OWNER_FREE     = 5'd0;
   localparam logic [OWNER_W-1:0] OWNER_RESERVED = 5'b11111;
   localparam logic [OWNER_W-1:0] OWNER_KERNEL   = 5'b11110;

   // used map: one bit per frame, packed into words
   localparam int WORD_BITS = 16;
   localparam int WORD_W    = $clog2(WORD_BITS);
   localparam int NUM_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int WSEL_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int FRAME_W   = WSEL_W + WORD_W;

   localparam logic [63:0] ADDR_LIMIT = 64'(NUM_FRAMES) << PAGE_BITS;

   // command queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // request kinds as they arrive
   localparam logic [KIND_W-1:0] REQ_ALLOC_NEXT = 3'd0;
   localparam logic [KIND_W-1:0] REQ_ASSIGN_AT  = 3'd1;
   localparam logic [KIND_W-1:0] REQ_FIND_FREE  = 3'd2;
   localparam logic [KIND_W-1:0] REQ_SHARE      = 3'd3;
   localparam logic [KIND_W-1:0] REQ_RELEASE    = 3'd4;
   localparam logic [KIND_W-1:0] REQ_FORCE_FREE = 3'd5;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_NOFREE  = 3'd1,
      ST_BADADDR = 3'd2,
      ST_TAKEN   = 3'd3,
      ST_LIMIT   = 3'd4
   } status_type;

   // classified operation carried through the queue
   typedef enum logic [2:0] {
      CMD_ALLOC,
      CMD_ASSIGN,
      CMD_FIND,
      CMD_SHARE,
      CMD_RELEASE,
      CMD_FREE,
      CMD_REJECT
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type         op;
      logic [FRAME_W-1:0] frame;
      logic [OWNER_W-1:0] owner;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_out_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_EXEC,
      BK_DONE
   } back_state_type;

   // bits of a map word that lie past the last frame; they count as used
   function automatic logic [WORD_BITS-1:0] pad_mask(input logic [WSEL_W-1:0] w);
      logic [WORD_BITS-1:0] m;
      int unsigned          base;
      base = 32'(w) * WORD_BITS;
      for (int b = 0; b < WORD_BITS; b++) begin
         m[b] = ((base + 32'(b)) >= 32'(NUM_FRAMES));
      end
      return m;
   endfunction

endpackage

// ----- src/ppra_req_if.sv -----
// ----------------------------------------------------------------------------
// ppra_req_if - request channel
// Valid/ready channel carrying one allocator request.
// ----------------------------------------------------------------------------
interface ppra_req_if import ppra_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [KIND_W-1:0]         req_type;
   logic [ADDR_W-1:0]         page_addr;
   logic [INDEX_W-1:0]        page_index;
   logic signed [OWNER_W-1:0] owner_id;

   modport source (output valid, req_type, page_addr, page_index, owner_id,
                   input ready);
   modport sink   (input valid, req_type, page_addr, page_index, owner_id,
                   output ready);
endinterface

// ----- src/ppra_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ppra_rsp_if - response channel
// Valid/ready channel carrying one allocator result.
// ----------------------------------------------------------------------------
interface ppra_rsp_if import ppra_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [FRNUM_W-1:0]  frame_number;
   logic [REF_W-1:0]    ref_count;

   modport source (output valid, status, frame_number, ref_count, input ready);
   modport sink   (input valid, status, frame_number, ref_count, output ready);
endinterface

// ----- src/ppra_front.sv -----
// ----------------------------------------------------------------------------
// ppra_front - request decode and command queue
// Checks addresses and indexes, turns each request into a command and
// holds it in a short queue for the back end.
// ----------------------------------------------------------------------------
module ppra_front import ppra_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   ppra_req_if.sink      req_if,
   output queue_out_type q_out,
   input  logic          q_pop
);

   cmd_type             q_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push;
   logic                pop;
   logic                addr_bad;
   logic                index_bad;
   cmd_type             cmd;

   assign req_if.ready = (count_ff != QCNT_W'(QDEPTH));
   assign push         = req_if.valid && req_if.ready;
   assign pop          = q_pop && (count_ff != '0);

   // range and alignment checks
   assign addr_bad  = (req_if.page_addr[PAGE_BITS-1:0] != '0) ||
                      (64'(req_if.page_addr) >= ADDR_LIMIT);
   assign index_bad = (32'(req_if.page_index) >= 32'(NUM_FRAMES));

   // classify request
   always_comb begin
      cmd.op    = CMD_REJECT;
      cmd.frame = FRAME_W'(req_if.page_index);
      cmd.owner = req_if.owner_id;
      unique case (req_if.req_type)
         REQ_ALLOC_NEXT: cmd.op = CMD_ALLOC;
         REQ_FIND_FREE:  cmd.op = CMD_FIND;
         REQ_ASSIGN_AT: begin
            cmd.frame = FRAME_W'(req_if.page_addr >> PAGE_BITS);
            cmd.op    = addr_bad ? CMD_REJECT : CMD_ASSIGN;
         end
         REQ_SHARE:      cmd.op = index_bad ? CMD_REJECT : CMD_SHARE;
         REQ_RELEASE:    cmd.op = index_bad ? CMD_REJECT : CMD_RELEASE;
         REQ_FORCE_FREE: cmd.op = index_bad ? CMD_REJECT : CMD_FREE;
         default:        cmd.op = CMD_REJECT;
      endcase
   end

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd;
      end
   end

   assign q_out.valid = (count_ff != '0);
   assign q_out.cmd   = q_ff[rd_ptr_ff];

endmodule

// ----- src/ppra_back.sv -----
// ----------------------------------------------------------------------------
// ppra_back - frame table execution
// Holds the reference counts, owners and the used map, runs one command
// at a time and drives the response register.
// ----------------------------------------------------------------------------
module ppra_back import ppra_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  queue_out_type q_out,
   output logic          q_pop,
   ppra_rsp_if.source    rsp_if
);

   // frame table and used map
   logic [REF_W-1:0]     refs_mem   [NUM_FRAMES];
   logic [OWNER_W-1:0]   owner_mem  [NUM_FRAMES];
   logic [WORD_BITS-1:0] bitmap_mem [NUM_WORDS];

   back_state_type       state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [WSEL_W-1:0]    word_ff, word_in;
   logic [WORD_BITS-1:0] bitmap_rd_ff;
   logic [REF_W-1:0]     refs_rd_ff;
   logic [NUM_WORDS-1:0] word_full_ff, word_full_in;
   logic [NUM_WORDS-1:0] word_valid_ff, word_valid_in;
   status_type           res_status_ff, res_status_in;
   logic [FRAME_W-1:0]   res_frame_ff, res_frame_in;
   logic [REF_W-1:0]     res_refs_ff, res_refs_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff;
   logic [FRAME_W-1:0]   rsp_frame_ff;
   logic [REF_W-1:0]     rsp_refs_ff;
   logic                 rsp_load;

   logic                 rd_en;
   logic                 refs_we;
   logic                 owner_we;
   logic [OWNER_W-1:0]   owner_wdata;
   logic [REF_W-1:0]     new_refs;
   logic [FRAME_W-1:0]   exec_frame;
   logic [WORD_BITS-1:0] used_word;
   logic [WORD_BITS-1:0] new_word;
   logic [WORD_BITS-1:0] free_bits;
   logic [WORD_W-1:0]    free_bit;
   logic [WSEL_W-1:0]    free_word;
   logic                 any_free_word;
   logic                 used_bit;
   logic [REF_W-1:0]     cur_refs;

   // lowest word with a free frame
   always_comb begin
      free_word     = '0;
      any_free_word = 1'b0;
      for (int i = NUM_WORDS - 1; i >= 0; i--) begin
         if (!word_full_ff[i]) begin
            free_word     = WSEL_W'(i);
            any_free_word = 1'b1;
         end
      end
   end

   // used map word as read; untouched words are all free
   assign used_word = word_valid_ff[word_ff] ? bitmap_rd_ff : '0;
   assign free_bits = ~(used_word | pad_mask(word_ff));

   // lowest free frame inside the word
   always_comb begin
      free_bit = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            free_bit = WORD_W'(i);
         end
      end
   end

   assign exec_frame = (cmd_ff.op == CMD_ALLOC || cmd_ff.op == CMD_FIND) ?
                       {word_ff, free_bit} : cmd_ff.frame;
   assign used_bit   = used_word[exec_frame[WORD_W-1:0]];
   assign cur_refs   = used_bit ? refs_rd_ff : '0;

   // sequencer and update logic
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      word_in       = word_ff;
      res_status_in = res_status_ff;
      res_frame_in  = res_frame_ff;
      res_refs_in   = res_refs_ff;
      word_full_in  = word_full_ff;
      word_valid_in = word_valid_ff;
      q_pop         = 1'b0;
      rd_en         = 1'b0;
      refs_we       = 1'b0;
      owner_we      = 1'b0;
      owner_wdata   = OWNER_FREE;
      new_refs      = cur_refs;
      new_word      = used_word;
      rsp_load      = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (q_out.valid) begin
               q_pop  = 1'b1;
               cmd_in = q_out.cmd;
               if (q_out.cmd.op == CMD_REJECT) begin
                  res_status_in = ST_BADADDR;
                  res_frame_in  = '0;
                  res_refs_in   = '0;
                  state_in      = BK_DONE;
               end else if (q_out.cmd.op == CMD_ALLOC || q_out.cmd.op == CMD_FIND) begin
                  word_in = free_word;
                  if (any_free_word) begin
                     state_in = BK_READ;
                  end else begin
                     res_status_in = ST_NOFREE;
                     res_frame_in  = '0;
                     res_refs_in   = '0;
                     state_in      = BK_DONE;
                  end
               end else begin
                  word_in  = q_out.cmd.frame[FRAME_W-1:WORD_W];
                  state_in = BK_READ;
               end
            end
         end

         BK_READ: begin
            rd_en    = 1'b1;
            state_in = BK_EXEC;
         end

         BK_EXEC: begin
            res_frame_in = exec_frame;
            res_status_in = ST_OK;
            case (cmd_ff.op)
               CMD_ALLOC: begin
                  new_refs    = 7'd1;
                  refs_we     = 1'b1;
                  owner_we    = 1'b1;
                  owner_wdata = cmd_ff.owner;
               end
               CMD_FIND: begin
                  new_refs = '0;
               end
               CMD_ASSIGN: begin
                  if (cur_refs != '0) begin
                     res_status_in = ST_TAKEN;
                  end else begin
                     new_refs    = 7'd1;
                     refs_we     = 1'b1;
                     owner_we    = 1'b1;
                     owner_wdata = cmd_ff.owner;
                  end
               end
               CMD_SHARE: begin
                  if (cur_refs >= REF_MAX) begin
                     res_status_in = ST_LIMIT;
                  end else begin
                     new_refs = cur_refs + 1'b1;
                     refs_we  = 1'b1;
                  end
               end
               CMD_RELEASE: begin
                  refs_we = 1'b1;
                  if (cur_refs == '0) begin
                     res_status_in = ST_LIMIT;
                     new_refs      = '0;
                     owner_we      = 1'b1;
                  end else begin
                     new_refs = cur_refs - 1'b1;
                     owner_we = (cur_refs == 7'd1);
                  end
               end
               CMD_FREE: begin
                  new_refs = '0;
                  refs_we  = 1'b1;
                  owner_we = 1'b1;
               end
               default: begin
                  res_status_in = ST_BADADDR;
                  new_refs      = '0;
               end
            endcase
            res_refs_in = new_refs;

            // keep the used map and summary in step with the count
            new_word[exec_frame[WORD_W-1:0]] = (new_refs != '0);
            if (refs_we) begin
               word_valid_in[word_ff] = 1'b1;
               word_full_in[word_ff]  = &(new_word | pad_mask(word_ff));
            end
            state_in = BK_DONE;
         end

         BK_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_load = 1'b1;
               state_in = BK_IDLE;
            end
         end

         default: state_in = BK_IDLE;
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         word_full_ff  <= '0;
         word_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         word_full_ff  <= word_full_in;
         word_valid_ff <= word_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      word_ff       <= word_in;
      res_status_ff <= res_status_in;
      res_frame_ff  <= res_frame_in;
      res_refs_ff   <= res_refs_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_frame_ff  <= res_frame_ff;
         rsp_refs_ff   <= res_refs_ff;
      end
   end

   // memory reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         bitmap_rd_ff <= bitmap_mem[word_ff];
         refs_rd_ff   <= refs_mem[cmd_ff.frame];
      end
   end

   // memory writes
   always_ff @(posedge clock) begin
      if (refs_we) begin
         refs_mem[exec_frame] <= new_refs;
         bitmap_mem[word_ff]  <= new_word;
      end
   end

   always_ff @(posedge clock) begin
      if (owner_we) begin
         owner_mem[exec_frame] <= owner_wdata;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.frame_number = FRNUM_W'(rsp_frame_ff);
   assign rsp_if.ref_count    = rsp_refs_ff;

endmodule

// ----- src/physical_page_refcount_allocator.sv -----
// ----------------------------------------------------------------------------
// physical_page_refcount_allocator - page frame allocator with refcounts
// Front end decodes requests into a command queue; back end owns the table.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one request (kind, byte address, frame index, owner);
//   rsp_if returns exactly one result per request, in request order.
//   Both are valid/ready channels; a request moves when both are high.
// Timing:
//   The front end registers each request into a two-entry queue at the
//   accepting edge. The back end then steps each command through pop,
//   used-map and count read, update and write-back, and response load. A
//   rejected request or one finding no free frame skips the table and
//   goes straight from pop to response load. The back end runs one
//   command at a time, a single read-modify-write pass over the table,
//   while the queue goes on taking requests until it is full.
// Reset:
//   Synchronous. All frames read as free straight after reset: the used
//   map words carry valid bits, so no clearing pass is needed.
// Stalls:
//   While a response waits in the output register the back end holds its
//   finished result and the front end keeps queueing up to two requests.
// ----------------------------------------------------------------------------
module physical_page_refcount_allocator import ppra_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ppra_req_if.sink   req_if,
   ppra_rsp_if.source rsp_if
);

   queue_out_type q_out;
   logic          q_pop;

   ppra_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .q_out  (q_out),
      .q_pop  (q_pop)
   );

   ppra_back u_back (
      .clock  (clock),
      .reset  (reset),
      .q_out  (q_out),
      .q_pop  (q_pop),
      .rsp_if (rsp_if)
   );

endmodule
